@@ src/atan2aa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2aa_pkg : shared constants and types for the angle approximation block
// Widths, fixed-point constants and the flag bundle carried down the pipeline.
// ----------------------------------------------------------------------------
package atan2aa_pkg;

	// input vector components
	localparam int COORD_BITS = 16;

	// ratio is Q14, the divider makes one extra bit for rounding
	localparam int RATIO_FRAC = 14;
	localparam int QUO_BITS   = RATIO_FRAC + 2;
	localparam int NUM_CELLS  = QUO_BITS;
	localparam int RATIO_BITS = RATIO_FRAC + 2;

	// polynomial datapath widths
	localparam int LINA_BITS = 34;
	localparam int QA_BITS   = RATIO_BITS + RATIO_FRAC + 1;
	localparam int SUM_BITS  = 49;
	localparam int SUM_SHIFT = 31;

	// angle widths, Q13
	localparam int ANGLE_BITS = 16;
	localparam int P_BITS     = 16;
	localparam int WIDE_BITS  = ANGLE_BITS + 2;

	localparam logic signed [17:0]           PI4_Q16  = 18'sd51472;
	localparam logic signed [15:0]           C273_Q16 = 16'sd17891;
	localparam logic signed [ANGLE_BITS-1:0] PI_Q13   = 16'sd25736;
	localparam logic signed [ANGLE_BITS-1:0] PI2_Q13  = 16'sd12868;

	// side information that travels alongside each request
	typedef struct packed {
		logic x_zero;
		logic y_neg;
		logic x_neg;
		logic swap;
	} atan2aa_flags_t;

endpackage

@@ src/atan2aa_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2aa_div_cell : one restoring divider cell
// Compares the incoming remainder with the divisor, yields one quotient bit
// and registers remainder, divisor, partial quotient and flags for the next cell.
// ----------------------------------------------------------------------------
module atan2aa_div_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  valid_in,
	input  logic [atan2aa_pkg::COORD_BITS-1:0]    rem_in,
	input  logic [atan2aa_pkg::COORD_BITS-1:0]    den_in,
	input  logic [atan2aa_pkg::QUO_BITS-1:0]      quo_in,
	input  atan2aa_pkg::atan2aa_flags_t           flags_in,
	output logic                                  valid_out,
	output logic [atan2aa_pkg::COORD_BITS-1:0]    rem_out,
	output logic [atan2aa_pkg::COORD_BITS-1:0]    den_out,
	output logic [atan2aa_pkg::QUO_BITS-1:0]      quo_out,
	output atan2aa_pkg::atan2aa_flags_t           flags_out
);

	logic                                  ge;
	logic [atan2aa_pkg::COORD_BITS-1:0]    rem_nx;
	logic                                  valid_s1;
	logic [atan2aa_pkg::COORD_BITS-1:0]    rem_s1;
	logic [atan2aa_pkg::COORD_BITS-1:0]    den_s1;
	logic [atan2aa_pkg::QUO_BITS-1:0]      quo_s1;
	atan2aa_pkg::atan2aa_flags_t           flags_s1;

	assign ge     = (rem_in >= den_in);
	assign rem_nx = ge ? (rem_in - den_in) : rem_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1   <= rem_nx;
			den_s1   <= den_in;
			quo_s1   <= {quo_in[atan2aa_pkg::QUO_BITS-2:0], ge};
			flags_s1 <= flags_in;
		end
	end

	assign valid_out = valid_s1;
	assign rem_out   = rem_s1;
	assign den_out   = den_s1;
	assign quo_out   = quo_s1;
	assign flags_out = flags_s1;

endmodule

@@ src/atan2aa_poly.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2aa_poly : ratio rounding and polynomial evaluation
// Four stages: signed Q14 ratio, first products, second product, sum and
// round to Q13.
// ----------------------------------------------------------------------------
module atan2aa_poly (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     valid_in,
	input  logic [atan2aa_pkg::QUO_BITS-1:0]         quo_in,
	input  atan2aa_pkg::atan2aa_flags_t              flags_in,
	output logic                                     valid_out,
	output logic signed [atan2aa_pkg::P_BITS-1:0]    p_out,
	output atan2aa_pkg::atan2aa_flags_t              flags_out
);

	localparam logic [atan2aa_pkg::RATIO_FRAC:0] ONE_Q14 =
		(atan2aa_pkg::RATIO_FRAC + 1)'(1) << atan2aa_pkg::RATIO_FRAC;
	localparam logic signed [atan2aa_pkg::SUM_BITS-1:0] ROUND_HALF =
		atan2aa_pkg::SUM_BITS'(1) << (atan2aa_pkg::SUM_SHIFT - 1);

	logic [3:0]                                       valid_q;
	atan2aa_pkg::atan2aa_flags_t                      flags_s1, flags_s2, flags_s3, flags_s4;

	logic [atan2aa_pkg::QUO_BITS:0]                   qinc;
	logic [atan2aa_pkg::QUO_BITS-1:0]                 qr;
	logic signed [atan2aa_pkg::RATIO_BITS-1:0]        r_nx;
	logic signed [atan2aa_pkg::RATIO_BITS-1:0]        r_s1;
	logic [atan2aa_pkg::RATIO_FRAC:0]                 ar_s1;

	logic [atan2aa_pkg::RATIO_FRAC:0]                 om;
	logic signed [atan2aa_pkg::LINA_BITS-1:0]         lin_s2;
	logic signed [atan2aa_pkg::QA_BITS-1:0]           qa_s2;

	logic signed [atan2aa_pkg::SUM_BITS-1:0]          lin_s3;
	logic signed [atan2aa_pkg::SUM_BITS-1:0]          quad_s3;

	logic signed [atan2aa_pkg::SUM_BITS-1:0]          sum;
	logic signed [atan2aa_pkg::P_BITS-1:0]            p_s4;

	// round half up of the doubled quotient, then apply the sign
	assign qinc = {1'b0, quo_in} + (atan2aa_pkg::QUO_BITS + 1)'(1);
	assign qr   = qinc[atan2aa_pkg::QUO_BITS:1];
	assign r_nx = (flags_in.y_neg ^ flags_in.x_neg) ? -signed'(qr) : signed'(qr);

	assign om  = ONE_Q14 - ar_s1;
	assign sum = lin_s3 + quad_s3 + ROUND_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[2:0], valid_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// ratio
			r_s1     <= r_nx;
			ar_s1    <= qr[atan2aa_pkg::RATIO_FRAC:0];
			flags_s1 <= flags_in;
			// pi/4 * r and r * (1 - |r|)
			lin_s2   <= atan2aa_pkg::LINA_BITS'(atan2aa_pkg::PI4_Q16)
				* atan2aa_pkg::LINA_BITS'(r_s1);
			qa_s2    <= atan2aa_pkg::QA_BITS'(r_s1)
				* atan2aa_pkg::QA_BITS'(signed'({1'b0, om}));
			flags_s2 <= flags_s1;
			// 0.273 * r * (1 - |r|), linear term aligned to Q44
			quad_s3  <= atan2aa_pkg::SUM_BITS'(atan2aa_pkg::C273_Q16)
				* atan2aa_pkg::SUM_BITS'(qa_s2);
			lin_s3   <= atan2aa_pkg::SUM_BITS'(
				signed'({lin_s2, {atan2aa_pkg::RATIO_FRAC{1'b0}}}));
			flags_s3 <= flags_s2;
			// round to Q13
			p_s4     <= signed'(sum[atan2aa_pkg::SUM_SHIFT+atan2aa_pkg::P_BITS-1:
				atan2aa_pkg::SUM_SHIFT]);
			flags_s4 <= flags_s3;
		end
	end

	assign valid_out = valid_q[3];
	assign p_out     = p_s4;
	assign flags_out = flags_s4;

endmodule

@@ src/atan2_angle_approx_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_angle_approx_top : pipelined four-quadrant arctangent
// Vector in, angle in radians (Q13) out, one request per clock while in_stall is low.
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid / in_stall, payload y_coord, x_coord (signed)
//   output channel : out_valid / out_stall, payload angle (signed Q13, -pi..pi)
//   a request is taken on a rising edge with valid high and stall low
// path
//   the angle of a request passes one front stage, sixteen divider cells, four
//   polynomial stages and the output register before it appears on out_valid
// throughput
//   one request per cycle while in_stall is low, set by the divider chain that yields
//   one quotient bit per cell and moves every request one cell onward each unfrozen cycle
// reset
//   arst_n clears all valid flags; no result is pending after reset
// back-pressure
//   a result held by out_stall parks in the output register, the next one in
//   a skid register; only with the skid full does the pipeline freeze and
//   in_stall rise, so in_stall is a registered signal
// ----------------------------------------------------------------------------
module atan2_angle_approx_top (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         in_valid,
	output logic                                         in_stall,
	input  logic signed [atan2aa_pkg::COORD_BITS-1:0]    y_coord,
	input  logic signed [atan2aa_pkg::COORD_BITS-1:0]    x_coord,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic signed [atan2aa_pkg::ANGLE_BITS-1:0]    angle
);

	localparam int CB = atan2aa_pkg::COORD_BITS;
	localparam int NC = atan2aa_pkg::NUM_CELLS;
	localparam int WB = atan2aa_pkg::WIDE_BITS;

	localparam logic signed [WB-1:0] PI_W  = WB'(atan2aa_pkg::PI_Q13);
	localparam logic signed [WB-1:0] PI2_W = WB'(atan2aa_pkg::PI2_Q13);

	// pipeline advances whenever the skid register is free
	logic en;

	// front stage: magnitudes, operand order, flags
	logic [CB-1:0]                 ay, ax;
	logic                          swap_nx;
	logic                          valid_s1;
	logic [CB-1:0]                 num_s1, den_s1;
	atan2aa_pkg::atan2aa_flags_t   flags_s1;

	// divider chain
	logic                          c_valid [0:NC];
	logic [CB-1:0]                 c_rem   [0:NC];
	logic [CB-1:0]                 c_den   [0:NC];
	logic [atan2aa_pkg::QUO_BITS-1:0] c_quo [0:NC];
	atan2aa_pkg::atan2aa_flags_t   c_flags [0:NC];
	logic [CB-1:0]                 c_rem_out [0:NC-1];

	// polynomial output
	logic                                         p_valid;
	logic signed [atan2aa_pkg::P_BITS-1:0]        p_val;
	atan2aa_pkg::atan2aa_flags_t                  p_flags;

	// final angle
	logic signed [WB-1:0]          p_w, base, turned, ang_w;
	logic signed [atan2aa_pkg::ANGLE_BITS-1:0] ang_nx;
	logic                          deliver;

	// output register and skid
	logic                                         out_valid_q;
	logic signed [atan2aa_pkg::ANGLE_BITS-1:0]    angle_q;
	logic                                         skid_valid_q;
	logic signed [atan2aa_pkg::ANGLE_BITS-1:0]    skid_angle_q;

	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	// --- front stage ---
	// magnitude of the most negative value wraps to the right unsigned value
	assign ay      = y_coord[CB-1] ? (~y_coord + CB'(1)) : y_coord;
	assign ax      = x_coord[CB-1] ? (~x_coord + CB'(1)) : x_coord;
	assign swap_nx = (ay > ax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1          <= swap_nx ? ax : ay;
			den_s1          <= swap_nx ? ay : ax;
			flags_s1.x_zero <= (x_coord == '0);
			flags_s1.y_neg  <= y_coord[CB-1];
			flags_s1.x_neg  <= x_coord[CB-1];
			flags_s1.swap   <= swap_nx;
		end
	end

	// --- divider chain: first cell sees the numerator as is, the rest
	// see the previous remainder doubled ---
	assign c_valid[0] = valid_s1;
	assign c_rem[0]   = num_s1;
	assign c_den[0]   = den_s1;
	assign c_quo[0]   = '0;
	assign c_flags[0] = flags_s1;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		atan2aa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (c_valid[i]),
			.rem_in    (c_rem[i]),
			.den_in    (c_den[i]),
			.quo_in    (c_quo[i]),
			.flags_in  (c_flags[i]),
			.valid_out (c_valid[i+1]),
			.rem_out   (c_rem_out[i]),
			.den_out   (c_den[i+1]),
			.quo_out   (c_quo[i+1]),
			.flags_out (c_flags[i+1])
		);
		// remainder stays below the divisor, so doubling never overflows
		assign c_rem[i+1] = {c_rem_out[i][CB-2:0], 1'b0};
	end

	// --- ratio and polynomial ---
	atan2aa_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (c_valid[NC]),
		.quo_in    (c_quo[NC]),
		.flags_in  (c_flags[NC]),
		.valid_out (p_valid),
		.p_out     (p_val),
		.flags_out (p_flags)
	);

	// --- octant and quadrant correction, saturation ---
	always_comb begin
		p_w = WB'(p_val);
		if (p_flags.swap) begin
			base = ((p_flags.y_neg ^ p_flags.x_neg) ? -PI2_W : PI2_W) - p_w;
		end else begin
			base = p_w;
		end
		if (p_flags.x_neg) begin
			turned = p_flags.y_neg ? (base - PI_W) : (base + PI_W);
		end else begin
			turned = base;
		end
		if (p_flags.x_zero) begin
			ang_w = p_flags.y_neg ? -PI2_W : PI2_W;
		end else if (turned > PI_W) begin
			ang_w = PI_W;
		end else if (turned < -PI_W) begin
			ang_w = -PI_W;
		end else begin
			ang_w = turned;
		end
		ang_nx = ang_w[atan2aa_pkg::ANGLE_BITS-1:0];
	end

	assign deliver = en && p_valid;

	// --- output register with skid ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			// output free: drain skid first, else take the pipeline
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= deliver;
			end
		end else if (deliver) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				angle_q <= skid_angle_q;
			end else if (deliver) begin
				angle_q <= ang_nx;
			end
		end else if (deliver) begin
			skid_angle_q <= ang_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign angle     = angle_q;

	// --- assertions ---
	// skid only holds a request behind a pending output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a request while the output register is empty");

	// skid fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall))
		else $error("skid filled without a stalled output");

	// delivered angle lies within -pi..pi
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (angle_q <= atan2aa_pkg::PI_Q13 && angle_q >= -atan2aa_pkg::PI_Q13))
		else $error("angle outside -pi..pi");

	// pipeline frozen while the skid is full
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && $past(skid_valid_q) |-> $stable(p_val))
		else $error("pipeline moved while the skid was full");

endmodule
